// ----- design/bankers_safety_check_unit_defines.svh -----
// Assertion macros shared by the safety check unit RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BANKERS_SAFETY_CHECK_UNIT_DEFINES_SVH
`define BANKERS_SAFETY_CHECK_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define BSC_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bsc assertion failed");

// next-cycle implication, disabled while reset is held
`define BSC_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bsc assertion failed");

`endif

// ----- design/bsc_pkg.sv -----
// Shared types, codes and the control store of the safety check unit.
// Depends on nothing; used by every module of the unit but the matrix memory.
package bsc_pkg;

    localparam int DEF_PROCESSES   = 8;
    localparam int DEF_RESOURCES   = 4;
    localparam int DEF_COUNT_WIDTH = 8;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_WR_MAX   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WR_AVAIL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK    = 2'd3;

    localparam int PROC_IDX_W = 3;
    localparam int RES_IDX_W  = 2;
    localparam int AMOUNT_W   = 8;
    localparam int AMT_EXT_W  = 16;
    localparam int SEQ_W      = 3;

    localparam int WORK_W = 11;
    localparam logic [WORK_W-1:0] WORK_MAX = 11'd2047;

    localparam int UPC_W  = 4;
    localparam int COND_W = 4;

    localparam logic [UPC_W-1:0] ST_CLEAR   = 4'd0;
    localparam logic [UPC_W-1:0] ST_IDLE    = 4'd1;
    localparam logic [UPC_W-1:0] ST_INIT    = 4'd2;
    localparam logic [UPC_W-1:0] ST_PROC    = 4'd3;
    localparam logic [UPC_W-1:0] ST_CHK_RD  = 4'd4;
    localparam logic [UPC_W-1:0] ST_CHK_EV  = 4'd5;
    localparam logic [UPC_W-1:0] ST_REL_RD  = 4'd6;
    localparam logic [UPC_W-1:0] ST_REL_EV  = 4'd7;
    localparam logic [UPC_W-1:0] ST_APPEND  = 4'd8;
    localparam logic [UPC_W-1:0] ST_NEXTP   = 4'd9;
    localparam logic [UPC_W-1:0] ST_PASS    = 4'd10;
    localparam logic [UPC_W-1:0] ST_RETRY   = 4'd11;
    localparam logic [UPC_W-1:0] ST_UNSAFE  = 4'd12;
    localparam logic [UPC_W-1:0] ST_SAFE    = 4'd13;
    localparam logic [UPC_W-1:0] ST_DONE    = 4'd14;

    localparam logic [COND_W-1:0] COND_NONE      = 4'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS    = 4'd1;
    localparam logic [COND_W-1:0] COND_NO_START  = 4'd2;
    localparam logic [COND_W-1:0] COND_FLAGGED   = 4'd3;
    localparam logic [COND_W-1:0] COND_MORE_R    = 4'd4;
    localparam logic [COND_W-1:0] COND_NO_FIT    = 4'd5;
    localparam logic [COND_W-1:0] COND_MORE_P    = 4'd6;
    localparam logic [COND_W-1:0] COND_ALL_FOUND = 4'd7;
    localparam logic [COND_W-1:0] COND_ANY       = 4'd8;
    localparam logic [COND_W-1:0] COND_MORE_CLR  = 4'd9;

    typedef struct packed {
        logic              in_ready;
        logic              mem_clr;
        logic              adv_rp;
        logic              init;
        logic              set_fit;
        logic              test_fit;
        logic              adv_r;
        logic              rel_work;
        logic              append;
        logic              adv_p;
        logic              clr_any;
        logic              wait_out;
        logic              emit_unsafe;
        logic              emit_seq;
        logic [COND_W-1:0] cond;
        logic [UPC_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic flagged;
        logic last_r;
        logic fit;
        logic last_p;
        logic all_found;
        logic any;
        logic out_busy;
    } stat_t;

    function automatic ctrl_t ucode(input logic [UPC_W-1:0] step);
        ctrl_t c;
        c = '0;
        case (step)
            ST_CLEAR: begin
                c.mem_clr = 1'b1; c.adv_rp = 1'b1;
                c.cond = COND_MORE_CLR; c.target = ST_CLEAR;
            end
            ST_IDLE: begin
                c.in_ready = 1'b1;
                c.cond = COND_NO_START; c.target = ST_IDLE;
            end
            ST_INIT: begin
                c.init = 1'b1;
            end
            ST_PROC: begin
                c.set_fit = 1'b1;
                c.cond = COND_FLAGGED; c.target = ST_NEXTP;
            end
            ST_CHK_RD: begin
                c.cond = COND_NONE;
            end
            ST_CHK_EV: begin
                c.test_fit = 1'b1; c.adv_r = 1'b1;
                c.cond = COND_MORE_R; c.target = ST_CHK_RD;
            end
            ST_REL_RD: begin
                c.cond = COND_NO_FIT; c.target = ST_NEXTP;
            end
            ST_REL_EV: begin
                c.rel_work = 1'b1; c.adv_r = 1'b1;
                c.cond = COND_MORE_R; c.target = ST_REL_RD;
            end
            ST_APPEND: begin
                c.append = 1'b1;
            end
            ST_NEXTP: begin
                c.adv_p = 1'b1;
                c.cond = COND_MORE_P; c.target = ST_PROC;
            end
            ST_PASS: begin
                c.cond = COND_ALL_FOUND; c.target = ST_SAFE;
            end
            ST_RETRY: begin
                c.clr_any = 1'b1;
                c.cond = COND_ANY; c.target = ST_PROC;
            end
            ST_UNSAFE: begin
                c.wait_out = 1'b1; c.emit_unsafe = 1'b1;
                c.cond = COND_ALWAYS; c.target = ST_IDLE;
            end
            ST_SAFE: begin
                c.wait_out = 1'b1; c.emit_seq = 1'b1; c.adv_p = 1'b1;
                c.cond = COND_MORE_P; c.target = ST_SAFE;
            end
            ST_DONE: begin
                c.cond = COND_ALWAYS; c.target = ST_IDLE;
            end
            default: begin
                c.cond = COND_ALWAYS; c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- design/bsc_ucode_seq.sv -----
// Microcode sequencer: step counter, control store lookup and branch test.
// Depends on bsc_pkg.
module bsc_ucode_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  bsc_pkg::stat_t stat_i,
    output bsc_pkg::ctrl_t ctrl_o
);

    logic [bsc_pkg::UPC_W-1:0] upc_reg;
    logic [bsc_pkg::UPC_W-1:0] upc_next;
    bsc_pkg::ctrl_t            word;
    logic                      taken;
    logic                      hold;

    assign word = bsc_pkg::ucode(upc_reg);
    assign hold = word.wait_out && stat_i.out_busy;

    always_comb begin
        case (word.cond)
            bsc_pkg::COND_NONE:      taken = 1'b0;
            bsc_pkg::COND_ALWAYS:    taken = 1'b1;
            bsc_pkg::COND_NO_START:  taken = !stat_i.start;
            bsc_pkg::COND_FLAGGED:   taken = stat_i.flagged;
            bsc_pkg::COND_MORE_R:    taken = !stat_i.last_r;
            bsc_pkg::COND_NO_FIT:    taken = !stat_i.fit;
            bsc_pkg::COND_MORE_P:    taken = !stat_i.last_p;
            bsc_pkg::COND_ALL_FOUND: taken = stat_i.all_found;
            bsc_pkg::COND_ANY:       taken = stat_i.any;
            bsc_pkg::COND_MORE_CLR:  taken = !(stat_i.last_r && stat_i.last_p);
            default:                 taken = 1'b0;
        endcase
    end

    always_comb begin
        if (hold) begin
            upc_next = upc_reg;
        end else if (taken) begin
            upc_next = word.target;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= bsc_pkg::ST_CLEAR;
        end else begin
            upc_reg <= upc_next;
        end
    end

    // stall: drop all actions while the result register is still occupied
    assign ctrl_o = hold ? '0 : word;

endmodule

// ----- design/bsc_matrix_mem.sv -----
// Maximum-claim and allocation matrices, one write and one registered read port each.
// Depends on nothing.
module bsc_matrix_mem #(
    parameter int AW = 5,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          we_max,
    input  logic          we_alloc,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] max_rd,
    output logic [DW-1:0] alloc_rd
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] max_mem   [DEPTH];
    logic [DW-1:0] alloc_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we_max) begin
            max_mem[waddr] <= wdata;
        end
        max_rd <= max_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (we_alloc) begin
            alloc_mem[waddr] <= wdata;
        end
        alloc_rd <= alloc_mem[raddr];
    end

endmodule

// ----- design/bsc_datapath.sv -----
// Datapath of the safety check: counters, work vector, flags, sequence, result register.
// Depends on bsc_pkg and bankers_safety_check_unit_defines.svh.
`include "bankers_safety_check_unit_defines.svh"

module bsc_datapath #(
    parameter int PROCESSES   = bsc_pkg::DEF_PROCESSES,
    parameter int RESOURCES   = bsc_pkg::DEF_RESOURCES,
    parameter int COUNT_WIDTH = bsc_pkg::DEF_COUNT_WIDTH,
    parameter int PW          = (PROCESSES > 1) ? $clog2(PROCESSES) : 1,
    parameter int RW          = (RESOURCES > 1) ? $clog2(RESOURCES) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bsc_pkg::ctrl_t                    ctrl_i,
    input  logic                              s_valid,
    input  logic [bsc_pkg::CMD_W-1:0]         s_cmd,
    input  logic [bsc_pkg::PROC_IDX_W-1:0]    s_proc_index,
    input  logic [bsc_pkg::RES_IDX_W-1:0]     s_res_index,
    input  logic [bsc_pkg::AMOUNT_W-1:0]      s_amount,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic                              m_safe,
    output logic [bsc_pkg::SEQ_W-1:0]         m_seq_position,
    output logic [bsc_pkg::SEQ_W-1:0]         m_proc_id,
    output logic                              m_last,
    output bsc_pkg::stat_t                    stat_o,
    output logic                              mem_we_max,
    output logic                              mem_we_alloc,
    output logic [PW+RW-1:0]                  mem_waddr,
    output logic [COUNT_WIDTH-1:0]            mem_wdata,
    output logic [PW+RW-1:0]                  mem_raddr,
    input  logic [COUNT_WIDTH-1:0]            max_rd,
    input  logic [COUNT_WIDTH-1:0]            alloc_rd
);

    localparam int FW    = $clog2(PROCESSES + 1);
    localparam int WK_W  = (COUNT_WIDTH > bsc_pkg::WORK_W) ? COUNT_WIDTH : bsc_pkg::WORK_W;
    localparam int CMP_W = WK_W + 2;

    logic [PW-1:0]          p_reg, p_next;
    logic [RW-1:0]          r_reg, r_next;
    logic [FW-1:0]          found_reg, found_next;
    logic                   any_reg, any_next;
    logic                   fit_reg, fit_next;
    logic [PROCESSES-1:0]   flags_reg, flags_next;
    logic                   m_valid_reg, m_valid_next;
    logic [COUNT_WIDTH-1:0] avail_reg [RESOURCES];
    logic [WK_W-1:0]        work_reg  [RESOURCES];
    logic [bsc_pkg::SEQ_W-1:0] seq_reg [PROCESSES];

    logic                   last_p, last_r;
    logic                   load_acc, proc_ok, res_ok;
    logic [bsc_pkg::AMT_EXT_W-1:0] amt_ext;
    logic [COUNT_WIDTH-1:0] amt;
    logic signed [CMP_W-1:0] need_s, work_s;
    logic                   need_over;
    logic [WK_W:0]          rel_sum;
    logic [WK_W-1:0]        rel_sat;
    logic                   emit;

    assign last_p   = (p_reg == PW'(PROCESSES - 1));
    assign last_r   = (r_reg == RW'(RESOURCES - 1));
    assign load_acc = s_valid && ctrl_i.in_ready;
    assign proc_ok  = (32'(s_proc_index) < PROCESSES);
    assign res_ok   = (32'(s_res_index) < RESOURCES);
    assign amt_ext  = bsc_pkg::AMT_EXT_W'(s_amount);
    assign amt      = amt_ext[COUNT_WIDTH-1:0];

    assign need_s    = $signed(CMP_W'(max_rd)) - $signed(CMP_W'(alloc_rd));
    assign work_s    = $signed(CMP_W'(work_reg[r_reg]));
    assign need_over = (need_s > work_s);

    assign rel_sum = (WK_W+1)'(work_reg[r_reg]) + (WK_W+1)'(alloc_rd);
    assign rel_sat = (rel_sum > (WK_W+1)'(bsc_pkg::WORK_MAX)) ?
                     WK_W'(bsc_pkg::WORK_MAX) : rel_sum[WK_W-1:0];

    assign emit = ctrl_i.emit_seq || ctrl_i.emit_unsafe;

    // matrix port: clearing sweep or a load transaction
    assign mem_we_max   = ctrl_i.mem_clr ||
                          (load_acc && s_cmd == bsc_pkg::CMD_WR_MAX && proc_ok && res_ok);
    assign mem_we_alloc = ctrl_i.mem_clr ||
                          (load_acc && s_cmd == bsc_pkg::CMD_WR_ALLOC && proc_ok && res_ok);
    assign mem_waddr    = ctrl_i.mem_clr ? {p_reg, r_reg} :
                          {PW'(s_proc_index), RW'(s_res_index)};
    assign mem_wdata    = ctrl_i.mem_clr ? '0 : amt;
    assign mem_raddr    = {p_reg, r_reg};

    always_comb begin
        p_next       = p_reg;
        r_next       = r_reg;
        found_next   = found_reg;
        any_next     = any_reg;
        fit_next     = fit_reg;
        flags_next   = flags_reg;
        m_valid_next = m_valid_reg;
        if (ctrl_i.init) begin
            p_next     = '0;
            r_next     = '0;
            found_next = '0;
            any_next   = 1'b0;
            flags_next = '0;
        end
        if (ctrl_i.adv_r || ctrl_i.adv_rp) begin
            r_next = last_r ? '0 : r_reg + 1'b1;
        end
        if (ctrl_i.adv_p || (ctrl_i.adv_rp && last_r)) begin
            p_next = last_p ? '0 : p_reg + 1'b1;
        end
        if (ctrl_i.set_fit) begin
            fit_next = 1'b1;
        end
        if (ctrl_i.test_fit && need_over) begin
            fit_next = 1'b0;
        end
        if (ctrl_i.clr_any) begin
            any_next = 1'b0;
        end
        if (ctrl_i.append) begin
            found_next        = found_reg + 1'b1;
            any_next          = 1'b1;
            flags_next[p_reg] = 1'b1;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg       <= '0;
            r_reg       <= '0;
            found_reg   <= '0;
            any_reg     <= 1'b0;
            fit_reg     <= 1'b0;
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < RESOURCES; i++) begin
                avail_reg[i] <= '0;
            end
        end else begin
            p_reg       <= p_next;
            r_reg       <= r_next;
            found_reg   <= found_next;
            any_reg     <= any_next;
            fit_reg     <= fit_next;
            flags_reg   <= flags_next;
            m_valid_reg <= m_valid_next;
            if (load_acc && s_cmd == bsc_pkg::CMD_WR_AVAIL && res_ok) begin
                avail_reg[RW'(s_res_index)] <= amt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.init) begin
            for (int i = 0; i < RESOURCES; i++) begin
                work_reg[i] <= WK_W'(avail_reg[i]);
            end
        end else if (ctrl_i.rel_work) begin
            work_reg[r_reg] <= rel_sat;
        end
        if (ctrl_i.append) begin
            seq_reg[found_reg[PW-1:0]] <= bsc_pkg::SEQ_W'(p_reg);
        end
        if (ctrl_i.emit_seq) begin
            m_safe         <= 1'b1;
            m_seq_position <= bsc_pkg::SEQ_W'(p_reg);
            m_proc_id      <= seq_reg[p_reg];
            m_last         <= last_p;
        end else if (ctrl_i.emit_unsafe) begin
            m_safe         <= 1'b0;
            m_seq_position <= '0;
            m_proc_id      <= '0;
            m_last         <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;

    assign stat_o.start     = s_valid && s_cmd == bsc_pkg::CMD_CHECK;
    assign stat_o.flagged   = flags_reg[p_reg];
    assign stat_o.last_r    = last_r;
    assign stat_o.fit       = fit_reg;
    assign stat_o.last_p    = last_p;
    assign stat_o.all_found = (found_reg == FW'(PROCESSES));
    assign stat_o.any       = any_reg;
    assign stat_o.out_busy  = m_valid_reg && !m_ready;

    `BSC_ASSERT_IMP(a_found_bound, aclk, aresetn, 1'b1, found_reg <= FW'(PROCESSES))
    `BSC_ASSERT_IMP(a_append_fresh, aclk, aresetn, ctrl_i.append, !flags_reg[p_reg])
    `BSC_ASSERT_IMP(a_emit_free, aclk, aresetn, emit, !(m_valid_reg && !m_ready))
    `BSC_ASSERT_NXT(a_emit_shows, aclk, aresetn, emit, m_valid_reg)

endmodule

// ----- design/bankers_safety_check_unit.sv -----
// Banker's algorithm safety check unit. A load transaction (max claim, allocation
// or available) writes one entry and returns nothing. A check transaction copies
// available into a work vector and makes whole passes over the processes; it
// returns one unsafe transaction, or PROCESSES transactions that carry the safe
// sequence in order. A microcoded sequencer over one shared matrix read port
// tests each unfinished process against work in every pass and, when it fits,
// adds its allocation back to work; results then leave one per cycle as m_ready
// allows. After reset a clearing sweep zeroes the matrices before the first
// transaction is accepted. The next transaction is accepted while the last
// result still waits in the output register.
module bankers_safety_check_unit #(
    parameter int PROCESSES   = bsc_pkg::DEF_PROCESSES,
    parameter int RESOURCES   = bsc_pkg::DEF_RESOURCES,
    parameter int COUNT_WIDTH = bsc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bsc_pkg::CMD_W-1:0]      s_cmd,
    input  logic [bsc_pkg::PROC_IDX_W-1:0] s_proc_index,
    input  logic [bsc_pkg::RES_IDX_W-1:0]  s_res_index,
    input  logic [bsc_pkg::AMOUNT_W-1:0]   s_amount,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_safe,
    output logic [bsc_pkg::SEQ_W-1:0]      m_seq_position,
    output logic [bsc_pkg::SEQ_W-1:0]      m_proc_id,
    output logic                           m_last
);

    localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int AW = PW + RW;

    bsc_pkg::ctrl_t         ctrl;
    bsc_pkg::stat_t         stat;
    logic                   mem_we_max;
    logic                   mem_we_alloc;
    logic [AW-1:0]          mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [COUNT_WIDTH-1:0] max_rd;
    logic [COUNT_WIDTH-1:0] alloc_rd;

    bsc_ucode_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat_i  (stat),
        .ctrl_o  (ctrl)
    );

    bsc_matrix_mem #(
        .AW (AW),
        .DW (COUNT_WIDTH)
    ) u_mem (
        .aclk     (aclk),
        .we_max   (mem_we_max),
        .we_alloc (mem_we_alloc),
        .waddr    (mem_waddr),
        .wdata    (mem_wdata),
        .raddr    (mem_raddr),
        .max_rd   (max_rd),
        .alloc_rd (alloc_rd)
    );

    bsc_datapath #(
        .PROCESSES   (PROCESSES),
        .RESOURCES   (RESOURCES),
        .COUNT_WIDTH (COUNT_WIDTH),
        .PW          (PW),
        .RW          (RW)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl_i         (ctrl),
        .s_valid        (s_valid),
        .s_cmd          (s_cmd),
        .s_proc_index   (s_proc_index),
        .s_res_index    (s_res_index),
        .s_amount       (s_amount),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_safe         (m_safe),
        .m_seq_position (m_seq_position),
        .m_proc_id      (m_proc_id),
        .m_last         (m_last),
        .stat_o         (stat),
        .mem_we_max     (mem_we_max),
        .mem_we_alloc   (mem_we_alloc),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .max_rd         (max_rd),
        .alloc_rd       (alloc_rd)
    );

    assign s_ready = ctrl.in_ready;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for bankers_safety_check_unit: loads claim, allocation and available
// counts, runs safety checks and compares each result with an in-bench predictor.
// Depends on bsc_pkg and the unit's RTL.
module testbench;

    localparam int NPROC        = bsc_pkg::DEF_PROCESSES;
    localparam int NRES         = bsc_pkg::DEF_RESOURCES;
    localparam int TOTAL_ITEMS  = 460;
    localparam int MAX_GAP      = 12;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef struct packed {
        logic [bsc_pkg::CMD_W-1:0]      cmd;
        logic [bsc_pkg::PROC_IDX_W-1:0] proc_index;
        logic [bsc_pkg::RES_IDX_W-1:0]  res_index;
        logic [bsc_pkg::AMOUNT_W-1:0]   amount;
    } command_t;

    typedef struct packed {
        logic                      safe;
        logic [bsc_pkg::SEQ_W-1:0] seq_position;
        logic [bsc_pkg::SEQ_W-1:0] proc_id;
        logic                      last;
    } verdict_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [bsc_pkg::CMD_W-1:0]      s_cmd = '0;
    logic [bsc_pkg::PROC_IDX_W-1:0] s_proc_index = '0;
    logic [bsc_pkg::RES_IDX_W-1:0]  s_res_index = '0;
    logic [bsc_pkg::AMOUNT_W-1:0]   s_amount = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic                           m_safe;
    logic [bsc_pkg::SEQ_W-1:0]      m_seq_position;
    logic [bsc_pkg::SEQ_W-1:0]      m_proc_id;
    logic                           m_last;

    bankers_safety_check_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_proc_index   (s_proc_index),
        .s_res_index    (s_res_index),
        .s_amount       (s_amount),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_safe         (m_safe),
        .m_seq_position (m_seq_position),
        .m_proc_id      (m_proc_id),
        .m_last         (m_last)
    );

    logic [bsc_pkg::AMOUNT_W-1:0] claim_tbl [NPROC][NRES];
    logic [bsc_pkg::AMOUNT_W-1:0] alloc_tbl [NPROC][NRES];
    logic [bsc_pkg::AMOUNT_W-1:0] avail_vec [NRES];

    command_t pending_cmds[$];
    verdict_t expected_verdicts[$];
    command_t in_flight;
    int       queued;
    int       accepted_cnt;
    int       mismatches;
    int       cycle_cnt;
    int       send_gap;
    int       recv_stall;
    bit       send_quiet;
    bit       recv_quiet;

    initial begin
        forever #1 aclk = ~aclk;
    end

    task automatic queue_cmd(input logic [bsc_pkg::CMD_W-1:0] cmd,
                             input logic [bsc_pkg::PROC_IDX_W-1:0] p,
                             input logic [bsc_pkg::RES_IDX_W-1:0] r,
                             input logic [bsc_pkg::AMOUNT_W-1:0] amt);
        command_t c;
        c.cmd        = cmd;
        c.proc_index = p;
        c.res_index  = r;
        c.amount     = amt;
        pending_cmds.push_back(c);
        queued++;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic int draw_wait(input bit quiet);
        if (quiet || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // update the tables, or run the safety check and queue its results
    function automatic void apply_command(input command_t c);
        logic [bsc_pkg::WORK_W-1:0] work [NRES];
        logic [bsc_pkg::WORK_W:0]   sum;
        bit                         done [NPROC];
        logic [bsc_pkg::SEQ_W-1:0]  order [NPROC];
        int                         found;
        bit                         progress;
        bit                         fits;
        verdict_t                   v;
        case (c.cmd)
            bsc_pkg::CMD_WR_MAX: begin
                claim_tbl[c.proc_index][c.res_index] = c.amount;
            end
            bsc_pkg::CMD_WR_ALLOC: begin
                alloc_tbl[c.proc_index][c.res_index] = c.amount;
            end
            bsc_pkg::CMD_WR_AVAIL: begin
                avail_vec[c.res_index] = c.amount;
            end
            default: begin
                for (int r = 0; r < NRES; r++)
                    work[r] = bsc_pkg::WORK_W'(avail_vec[r]);
                for (int p = 0; p < NPROC; p++)
                    done[p] = 1'b0;
                found    = 0;
                progress = 1'b1;
                while (found < NPROC && progress) begin
                    progress = 1'b0;
                    for (int p = 0; p < NPROC; p++) begin
                        if (!done[p]) begin
                            fits = 1'b1;
                            for (int r = 0; r < NRES; r++)
                                if (int'(claim_tbl[p][r]) - int'(alloc_tbl[p][r]) > int'(work[r]))
                                    fits = 1'b0;
                            if (fits) begin
                                for (int r = 0; r < NRES; r++) begin
                                    sum = work[r] + alloc_tbl[p][r];
                                    work[r] = (sum > bsc_pkg::WORK_MAX) ? bsc_pkg::WORK_MAX
                                                                        : sum[bsc_pkg::WORK_W-1:0];
                                end
                                order[found] = bsc_pkg::SEQ_W'(p);
                                found++;
                                done[p]  = 1'b1;
                                progress = 1'b1;
                            end
                        end
                    end
                end
                if (found < NPROC) begin
                    v = '{1'b0, '0, '0, 1'b1};
                    expected_verdicts.push_back(v);
                end else begin
                    for (int k = 0; k < NPROC; k++) begin
                        v = '{1'b1, bsc_pkg::SEQ_W'(k), order[k], (k == NPROC - 1)};
                        expected_verdicts.push_back(v);
                    end
                end
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        command_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_command(in_flight);
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    nxt = pending_cmds.pop_front();
                    in_flight = nxt;
                    s_cmd        <= nxt.cmd;
                    s_proc_index <= nxt.proc_index;
                    s_res_index  <= nxt.res_index;
                    s_amount     <= nxt.amount;
                    s_valid      <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_quiet = !send_quiet;
                    send_gap = draw_wait(send_quiet);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result safe=%0b pos=%0d proc=%0d last=%0b",
                                              m_safe, m_seq_position, m_proc_id, m_last));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_safe !== want.safe)
                        report_mismatch($sformatf("safe got %0b want %0b", m_safe, want.safe));
                    if (m_seq_position !== want.seq_position)
                        report_mismatch($sformatf("seq_position got %0d want %0d",
                                                  m_seq_position, want.seq_position));
                    if (m_proc_id !== want.proc_id)
                        report_mismatch($sformatf("proc_id got %0d want %0d at position %0d",
                                                  m_proc_id, want.proc_id, want.seq_position));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b", m_last, want.last));
                end
                if ($urandom_range(0, 39) == 0)
                    recv_quiet = !recv_quiet;
                recv_stall = draw_wait(recv_quiet);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int p;
        int r;
        int span;
        int hi;
        int lo;
        for (int i = 0; i < NPROC; i++)
            for (int j = 0; j < NRES; j++) begin
                claim_tbl[i][j] = '0;
                alloc_tbl[i][j] = '0;
            end
        for (int j = 0; j < NRES; j++)
            avail_vec[j] = '0;

        // all-zero tables are safe; a claim with nothing available is not
        queue_cmd(bsc_pkg::CMD_CHECK, 3'd0, 2'd0, 8'd0);
        queue_cmd(bsc_pkg::CMD_WR_MAX, 3'd7, 2'd3, 8'd255);
        queue_cmd(bsc_pkg::CMD_CHECK, 3'd7, 2'd3, 8'd255);
        queue_cmd(bsc_pkg::CMD_WR_AVAIL, 3'd5, 2'd3, 8'd255);
        queue_cmd(bsc_pkg::CMD_CHECK, 3'd2, 2'd1, 8'd170);
        // allocation above claim, then enough released to saturate work
        for (int i = 0; i < NPROC; i++)
            queue_cmd(bsc_pkg::CMD_WR_ALLOC, 3'(i), 2'd0, 8'd255);
        queue_cmd(bsc_pkg::CMD_WR_AVAIL, 3'd0, 2'd0, 8'd255);
        queue_cmd(bsc_pkg::CMD_CHECK, 3'd5, 2'd2, 8'd85);
        // process 0 fits only after process 5 releases, on a second pass
        queue_cmd(bsc_pkg::CMD_WR_MAX, 3'd0, 2'd1, 8'd10);
        queue_cmd(bsc_pkg::CMD_WR_ALLOC, 3'd5, 2'd1, 8'd10);
        queue_cmd(bsc_pkg::CMD_CHECK, 3'd1, 2'd2, 8'd1);

        while (queued < TOTAL_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 4))
                        queue_cmd(2'($urandom_range(0, 3)), 3'($urandom), 2'($urandom),
                                  8'($urandom));
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: span = 3;
                        1: span = 15;
                        2: span = 63;
                        default: span = 255;
                    endcase
                    repeat ($urandom_range(1, 6)) begin
                        p  = $urandom_range(0, NPROC - 1);
                        r  = $urandom_range(0, NRES - 1);
                        hi = $urandom_range(0, span);
                        lo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(0, hi);
                        queue_cmd(bsc_pkg::CMD_WR_MAX, 3'(p), 2'(r), 8'(hi));
                        queue_cmd(bsc_pkg::CMD_WR_ALLOC, 3'(p), 2'(r), 8'(lo));
                    end
                    repeat ($urandom_range(0, 3))
                        queue_cmd(bsc_pkg::CMD_WR_AVAIL, 3'($urandom),
                                  2'($urandom_range(0, NRES - 1)),
                                  8'($urandom_range(0, span)));
                    queue_cmd(bsc_pkg::CMD_CHECK, 3'($urandom), 2'($urandom), 8'($urandom));
                end
            endcase
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (accepted_cnt < queued)
            @(posedge aclk);
        while (expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/bsc_pkg.sv
design/bsc_ucode_seq.sv
design/bsc_matrix_mem.sv
design/bsc_datapath.sv
design/bankers_safety_check_unit.sv
verif/testbench.sv
